// File: sv/lnpe_pkg.sv
// Package for the line-number program encoder: transaction structs,
// opcode constants and the control structs of the shared shift unit.
// No dependencies.
`default_nettype none

package lnpe_pkg;

   localparam int LNPE_LINE_BITS = 24;
   localparam int LNPE_ADDR_W    = 64;

   // Standard opcodes
   localparam logic [7:0] LNPE_OP_EXTENDED       = 8'd0;
   localparam logic [7:0] LNPE_OP_COPY           = 8'd1;
   localparam logic [7:0] LNPE_OP_ADVANCE_LINE   = 8'd3;
   localparam logic [7:0] LNPE_OP_SET_FILE       = 8'd4;
   localparam logic [7:0] LNPE_OP_SET_COLUMN     = 8'd5;
   localparam logic [7:0] LNPE_OP_PROLOGUE_END   = 8'd10;
   localparam logic [7:0] LNPE_OP_EPILOGUE_BEGIN = 8'd11;

   // Extended opcodes and their lengths
   localparam logic [7:0] LNPE_EXT_LEN_ADDR = 8'd9;
   localparam logic [7:0] LNPE_EXT_SET_ADDR = 8'd2;
   localparam logic [7:0] LNPE_EXT_LEN_END  = 8'd1;
   localparam logic [7:0] LNPE_EXT_END_SEQ  = 8'd1;

   typedef struct packed {
      logic        cmd;
      logic [63:0] address;
      logic [23:0] line;
      logic [15:0] column;
      logic [7:0]  file_index;
      logic        prologue_end;
      logic        epilogue_begin;
   } lnpe_req_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } lnpe_rsp_type;

   typedef struct packed {
      logic load;  // take load_value, set mode below
      logic step;  // advance by one output byte
      logic leb;   // 1: LEB128 digits of 7 bits, 0: raw bytes
      logic sgn;   // signed LEB128
   } lnpe_unit_ctrl_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last;        // final LEB128 digit
   } lnpe_unit_out_type;

endpackage

`default_nettype wire

// File: sv/lnpe_shift_unit.sv
// Shared shift unit: emits an address byte by byte or a value as
// ULEB128/SLEB128 digits, one per step. Depends on lnpe_pkg.
`default_nettype none

module lnpe_shift_unit
   import lnpe_pkg::*;
(
   input  wire logic                    clock,
   input  wire lnpe_unit_ctrl_type      ctrl,
   input  wire logic [LNPE_ADDR_W-1:0]  load_value,
   output lnpe_unit_out_type            unit_out
);

   logic [LNPE_ADDR_W-1:0] sh_ff, sh_in;
   logic                   leb_ff, leb_in;
   logic                   sgn_ff, sgn_in;

   logic [6:0]             chunk;
   logic [LNPE_ADDR_W-1:0] rest;
   logic                   leb_last;

   always_comb begin
      chunk = sh_ff[6:0];
      rest  = {{7{sgn_ff & sh_ff[LNPE_ADDR_W-1]}}, sh_ff[LNPE_ADDR_W-1:7]};
      // signed: stop once the rest is pure sign and digit bit 6 agrees
      if (sgn_ff) begin
         leb_last = ((rest == '0) && !chunk[6]) || ((&rest) && chunk[6]);
      end else begin
         leb_last = (rest == '0);
      end
      unit_out.last       = leb_last;
      unit_out.byte_value = leb_ff ? {~leb_last, chunk} : sh_ff[7:0];

      sh_in  = sh_ff;
      leb_in = leb_ff;
      sgn_in = sgn_ff;
      if (ctrl.load) begin
         sh_in  = load_value;
         leb_in = ctrl.leb;
         sgn_in = ctrl.sgn;
      end else if (ctrl.step) begin
         sh_in = leb_ff ? rest : {8'd0, sh_ff[LNPE_ADDR_W-1:8]};
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      leb_ff <= leb_in;
      sgn_ff <= sgn_in;
   end

endmodule

`default_nettype wire

// File: sv/line_number_program_encoder.sv
// Line-number program encoder. A row transaction is taken while idle, then its
// 12 to 26 bytes leave at one per cycle while the consumer keeps rsp_ready high;
// address bytes and LEB128 digits come from the shared shift unit.
// A finish after rows produces 3 bytes; a finish with no rows produces none.
// req_ready is high only between items. Synchronous reset: held line and
// file return to 1, no rows seen, output empty.
`default_nettype none

module line_number_program_encoder
   import lnpe_pkg::*;
#(
   parameter int LINE_BITS = LNPE_LINE_BITS
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire lnpe_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output lnpe_rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_HDR, S_ADDR, S_OP, S_LEB, S_TAIL, S_FIN
   } state_type;

   state_type              state_ff, state_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [LINE_BITS-1:0]   held_line_ff, held_line_in;
   logic [7:0]             held_file_ff, held_file_in;
   logic                   rows_seen_ff, rows_seen_in;
   logic                   file_pend_ff, file_pend_in;
   logic                   line_pend_ff, line_pend_in;
   logic                   col_pend_ff, col_pend_in;
   logic                   pro_ff, pro_in;
   logic                   epi_ff, epi_in;
   logic [7:0]             file_ff, file_in;
   logic [15:0]            col_ff, col_in;
   logic [LINE_BITS:0]     delta_ff, delta_in;
   logic [7:0]             op_ff, op_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lnpe_rsp_type           rsp_data_ff, rsp_data_in;

   lnpe_unit_ctrl_type     ctrl;
   lnpe_unit_out_type      unit_out;
   logic [LNPE_ADDR_W-1:0] load_value;

   logic                   out_free;
   logic                   emit;
   logic [7:0]             emit_byte;
   logic                   emit_last;
   logic                   go_next;
   logic [LINE_BITS-1:0]   line_m;

   lnpe_shift_unit u_shift_unit (
      .clock      (clock),
      .ctrl       (ctrl),
      .load_value (load_value),
      .unit_out   (unit_out)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign line_m    = LINE_BITS'(req_data.line);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      held_line_in = held_line_ff;
      held_file_in = held_file_ff;
      rows_seen_in = rows_seen_ff;
      file_pend_in = file_pend_ff;
      line_pend_in = line_pend_ff;
      col_pend_in  = col_pend_ff;
      pro_in       = pro_ff;
      epi_in       = epi_ff;
      file_in      = file_ff;
      col_in       = col_ff;
      delta_in     = delta_ff;
      op_in        = op_ff;
      ctrl         = '0;
      load_value   = req_data.address;
      emit         = 1'b0;
      emit_byte    = LNPE_OP_EXTENDED;
      emit_last    = 1'b0;
      go_next      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.cmd) begin
                  if (rows_seen_ff) begin
                     state_in = S_FIN;
                     cnt_in   = 3'd0;
                  end
                  held_line_in = LINE_BITS'(1);
                  held_file_in = 8'd1;
                  rows_seen_in = 1'b0;
               end else begin
                  ctrl.load    = 1'b1;
                  file_pend_in = (req_data.file_index != held_file_ff);
                  held_file_in = req_data.file_index;
                  file_in      = req_data.file_index;
                  line_pend_in = (line_m != held_line_ff);
                  delta_in     = {1'b0, line_m} - {1'b0, held_line_ff};
                  held_line_in = line_m;
                  col_pend_in  = (req_data.column != 16'd0);
                  col_in       = req_data.column;
                  pro_in       = req_data.prologue_end;
                  epi_in       = req_data.epilogue_begin;
                  rows_seen_in = 1'b1;
                  cnt_in       = 3'd0;
                  state_in     = S_HDR;
               end
            end
         end
         S_HDR: begin
            if (out_free) begin
               emit = 1'b1;
               case (cnt_ff)
                  3'd0:    emit_byte = LNPE_OP_EXTENDED;
                  3'd1:    emit_byte = LNPE_EXT_LEN_ADDR;
                  3'd2:    emit_byte = LNPE_EXT_SET_ADDR;
                  default: emit_byte = LNPE_OP_EXTENDED;
               endcase
               if (cnt_ff == 3'd2) begin
                  cnt_in   = 3'd0;
                  state_in = S_ADDR;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         end
         S_ADDR: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = unit_out.byte_value;
               ctrl.step = 1'b1;
               if (cnt_ff == 3'd7) begin
                  go_next = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         end
         S_OP: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = op_ff;
               state_in  = S_LEB;
            end
         end
         S_LEB: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = unit_out.byte_value;
               ctrl.step = 1'b1;
               go_next   = unit_out.last;
            end
         end
         S_TAIL: begin
            if (out_free) begin
               emit = 1'b1;
               if (pro_ff) begin
                  emit_byte = LNPE_OP_PROLOGUE_END;
                  pro_in    = 1'b0;
               end else if (epi_ff) begin
                  emit_byte = LNPE_OP_EPILOGUE_BEGIN;
                  epi_in    = 1'b0;
               end else begin
                  emit_byte = LNPE_OP_COPY;
                  emit_last = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               emit = 1'b1;
               case (cnt_ff)
                  3'd0:    emit_byte = LNPE_OP_EXTENDED;
                  3'd1:    emit_byte = LNPE_EXT_LEN_END;
                  3'd2:    emit_byte = LNPE_EXT_END_SEQ;
                  default: emit_byte = LNPE_OP_EXTENDED;
               endcase
               if (cnt_ff == 3'd2) begin
                  emit_last = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Pick the next optional field (or the tail when none is left); its opcode
      // goes out first, then the unit (loaded here) streams its LEB128 digits.
      if (go_next) begin
         ctrl.leb = 1'b1;
         if (file_pend_ff) begin
            ctrl.load    = 1'b1;
            load_value   = LNPE_ADDR_W'(file_ff);
            op_in        = LNPE_OP_SET_FILE;
            file_pend_in = 1'b0;
            state_in     = S_OP;
         end else if (line_pend_ff) begin
            ctrl.load    = 1'b1;
            ctrl.sgn     = 1'b1;
            load_value   = {{(LNPE_ADDR_W-LINE_BITS-1){delta_ff[LINE_BITS]}}, delta_ff};
            op_in        = LNPE_OP_ADVANCE_LINE;
            line_pend_in = 1'b0;
            state_in     = S_OP;
         end else if (col_pend_ff) begin
            ctrl.load   = 1'b1;
            load_value  = LNPE_ADDR_W'(col_ff);
            op_in       = LNPE_OP_SET_COLUMN;
            col_pend_in = 1'b0;
            state_in    = S_OP;
         end else begin
            state_in = S_TAIL;
         end
      end

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || emit;
      rsp_data_in  = emit ? lnpe_rsp_type'{byte_value: emit_byte, last_byte: emit_last}
                          : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 3'd0;
         held_line_ff <= LINE_BITS'(1);
         held_file_ff <= 8'd1;
         rows_seen_ff <= 1'b0;
         file_pend_ff <= 1'b0;
         line_pend_ff <= 1'b0;
         col_pend_ff  <= 1'b0;
         pro_ff       <= 1'b0;
         epi_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         held_line_ff <= held_line_in;
         held_file_ff <= held_file_in;
         rows_seen_ff <= rows_seen_in;
         file_pend_ff <= file_pend_in;
         line_pend_ff <= line_pend_in;
         col_pend_ff  <= col_pend_in;
         pro_ff       <= pro_in;
         epi_ff       <= epi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      file_ff     <= file_in;
      col_ff      <= col_in;
      delta_ff    <= delta_in;
      op_ff       <= op_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// File: sv/lnpe_checker.sv
// Port-level checker for the line-number program encoder, bound to the top.
// Depends on lnpe_pkg.
`default_nettype none

module lnpe_checker
   import lnpe_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire lnpe_req_type req_data,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire lnpe_rsp_type rsp_data
);

   // a row always produces bytes, so the block is busy right after taking one
   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.cmd |=> !req_ready)
      else $error("ready after row transaction");

   // every item that produces bytes ends on a copy or end-sequence byte
   a_last_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_byte |->
         (rsp_data.byte_value == LNPE_OP_COPY) || (rsp_data.byte_value == LNPE_EXT_END_SEQ))
      else $error("last byte is not a closing opcode");

   // while idle, only the closing byte of the previous item may be pending
   a_idle_output: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_data.last_byte)
      else $error("ready with an item still streaming");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind line_number_program_encoder lnpe_checker u_lnpe_checker (.*);

`default_nettype wire

// File: sim/line_number_program_encoder_test.sv
// Testbench for line_number_program_encoder: random and directed line rows and finish
// commands, checked byte by byte against a predictor of the DWARF4 line program.
// Depends on lnpe_pkg and the encoder RTL.
module line_number_program_encoder_test
   import lnpe_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 40;
   localparam int PHASE_ITEMS   = 100;

   class line_program_scoreboard;
      logic [23:0] held_line;
      logic [7:0]  held_file;
      bit          rows_seen;
      logic [7:0]  row_bytes[$];
      lnpe_rsp_type expected_bytes[$];
      int          errors;

      function new();
         clear_state();
         errors = 0;
      endfunction

      function void clear_state();
         held_line = 24'd1;
         held_file = 8'd1;
         rows_seen = 1'b0;
      endfunction

      function void add_byte(logic [7:0] value);
         row_bytes.insert(row_bytes.size(), value);
      endfunction

      function void push_uleb(longint unsigned value);
         logic [6:0] digit;
         do begin
            digit = value[6:0];
            value = value >> 7;
            add_byte({value != 0, digit});
         end while (value != 0);
      endfunction

      function void push_sleb(longint signed value);
         logic [6:0] digit;
         bit         done;
         done = 1'b0;
         while (!done) begin
            digit = value[6:0];
            value = value >>> 7;
            // stop once the remaining bits are pure sign extension of bit 6
            if ((value == 0 && !digit[6]) || (value == -1 && digit[6])) begin
               add_byte({1'b0, digit});
               done = 1'b1;
            end else begin
               add_byte({1'b1, digit});
            end
         end
      endfunction

      // Works out the bytes one accepted transaction produces.
      function void note_request(lnpe_req_type req);
         logic [23:0]  line_mask;
         logic [23:0]  line;
         lnpe_rsp_type rsp;
         line_mask = 24'((64'd1 << LNPE_LINE_BITS) - 64'd1);
         row_bytes.delete();
         if (req.cmd) begin
            if (rows_seen) begin
               add_byte(LNPE_OP_EXTENDED);
               add_byte(LNPE_EXT_LEN_END);
               add_byte(LNPE_EXT_END_SEQ);
            end
            clear_state();
         end else begin
            line = req.line & line_mask;
            add_byte(LNPE_OP_EXTENDED);
            add_byte(LNPE_EXT_LEN_ADDR);
            add_byte(LNPE_EXT_SET_ADDR);
            for (int i = 0; i < 8; i++) begin
               add_byte(req.address[8*i +: 8]);
            end
            if (req.file_index != held_file) begin
               add_byte(LNPE_OP_SET_FILE);
               push_uleb(longint'(req.file_index));
               held_file = req.file_index;
            end
            if (line != held_line) begin
               add_byte(LNPE_OP_ADVANCE_LINE);
               push_sleb(longint'(line) - longint'(held_line));
            end
            held_line = line;
            if (req.column != 16'd0) begin
               add_byte(LNPE_OP_SET_COLUMN);
               push_uleb(longint'(req.column));
            end
            if (req.prologue_end) add_byte(LNPE_OP_PROLOGUE_END);
            if (req.epilogue_begin) add_byte(LNPE_OP_EPILOGUE_BEGIN);
            add_byte(LNPE_OP_COPY);
            rows_seen = 1'b1;
         end
         for (int i = 0; i < row_bytes.size(); i++) begin
            rsp.byte_value = row_bytes[i];
            rsp.last_byte  = (i == row_bytes.size() - 1);
            expected_bytes.insert(expected_bytes.size(), rsp);
         end
      endfunction

      function void check_response(lnpe_rsp_type rsp);
         lnpe_rsp_type want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte %h last %b", $time, rsp.byte_value, rsp.last_byte);
            errors++;
            return;
         end
         want = expected_bytes.pop_front();
         if (rsp.byte_value !== want.byte_value) begin
            $display("%0t: byte_value expected %h actual %h", $time, want.byte_value,
                     rsp.byte_value);
            errors++;
         end
         if (rsp.last_byte !== want.last_byte) begin
            $display("%0t: last_byte expected %b actual %b", $time, want.last_byte,
                     rsp.last_byte);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   lnpe_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   lnpe_rsp_type rsp_data;

   line_program_scoreboard sb = new();

   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_request;
   logic [63:0] next_address;
   logic [23:0] gen_line;
   logic [7:0]  gen_file;

   line_number_program_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic lnpe_req_type make_request(logic cmd, logic [63:0] address,
                                                 logic [23:0] line, logic [15:0] column,
                                                 logic [7:0] file_index, logic pe,
                                                 logic eb);
      lnpe_req_type req;
      req.cmd            = cmd;
      req.address        = address;
      req.line           = line;
      req.column         = column;
      req.file_index     = file_index;
      req.prologue_end   = pe;
      req.epilogue_begin = eb;
      return req;
   endfunction

   // Rows mostly follow an ascending address and nearby lines; some noise and about one finish in ten mixed in.
   function automatic lnpe_req_type random_request();
      lnpe_req_type req;
      int           pick;
      int           delta;
      req = make_request(1'b0, {$urandom, $urandom}, 24'($urandom), 16'($urandom),
                         8'($urandom), 1'($urandom), 1'($urandom));
      if ($urandom_range(99) < 10) begin
         req.cmd  = 1'b1;
         gen_line = 24'd1;
         gen_file = 8'd1;
         return req;
      end
      if ($urandom_range(7) != 0) begin
         next_address = next_address + 64'($urandom_range(1, 64));
         req.address  = next_address;
      end
      pick = $urandom_range(9);
      if (pick <= 2) begin
         req.line = gen_line;
      end else if (pick <= 8) begin
         delta = (pick <= 6) ? $urandom_range(1, 70) : $urandom_range(1, 20000);
         if ($urandom_range(1)) delta = -delta;
         req.line = gen_line + 24'(delta);
      end
      gen_line = req.line;
      if ($urandom_range(99) < 60) req.file_index = gen_file;
      gen_file = req.file_index;
      pick = $urandom_range(9);
      if (pick <= 2) req.column = 16'd0;
      else if (pick <= 6) req.column = 16'($urandom_range(1, 200));
      req.prologue_end   = ($urandom_range(3) == 0);
      req.epilogue_begin = ($urandom_range(3) == 0);
      return req;
   endfunction

   task automatic send_item(lnpe_req_type req);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (!req_ready);
      sb.note_request(req);
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) begin
         send_item(random_request());
      end
   endtask

   // Receiver: checks each byte and drives rsp_ready, with one long hold-off when a phase requests it.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (hold_left == 0 && hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data      <= '0;
      send_idle_pct = 21;
      recv_idle_pct = 52;
      hold_request  = 1'b0;
      next_address  = 64'h1000;
      gen_line      = 24'd1;
      gen_file      = 8'd1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // finish before any row, then single-byte and two-byte LEB boundaries
      send_item(make_request(1'b1, 64'd0, 24'd0, 16'd0, 8'd0, 1'b0, 1'b0));
      send_item(make_request(1'b0, 64'd0, 24'd1, 16'd0, 8'd1, 1'b0, 1'b0));
      send_item(make_request(1'b0, 64'h10, 24'd64, 16'd127, 8'd1, 1'b0, 1'b0));
      send_item(make_request(1'b0, 64'h20, 24'd128, 16'd128, 8'd2, 1'b0, 1'b0));
      send_item(make_request(1'b0, 64'h30, 24'd63, 16'd1, 8'd2, 1'b1, 1'b0));
      send_item(make_request(1'b0, 64'h40, 24'd62, 16'd0, 8'd127, 1'b0, 1'b1));
      send_item(make_request(1'b0, 64'h50, 24'd126, 16'd0, 8'd128, 1'b0, 1'b0));
      // file zero, then zero again with no change
      send_item(make_request(1'b0, 64'h60, 24'd126, 16'd0, 8'd0, 1'b0, 1'b0));
      send_item(make_request(1'b0, 64'h70, 24'd0, 16'd0, 8'd0, 1'b0, 1'b0));
      send_item(make_request(1'b0, 64'h80, 24'hffffff, 16'hffff, 8'd255, 1'b1, 1'b1));
      send_item(make_request(1'b0, 64'h90, 24'd0, 16'd0, 8'd255, 1'b0, 1'b0));
      // largest row: big file, full line swing, widest column, both flags
      send_item(make_request(1'b0, 64'hffff_ffff_ffff_ffff, 24'hffffff, 16'hffff, 8'd200,
                             1'b1, 1'b1));
      send_item(make_request(1'b0, 64'h5555_aaaa_5555_aaaa, 24'h000001, 16'd1, 8'd200,
                             1'b0, 1'b0));
      // addresses out of order are encoded as given
      send_item(make_request(1'b0, 64'haaaa_5555_aaaa_5555, 24'h800000, 16'd8191, 8'd1,
                             1'b0, 1'b0));
      send_item(make_request(1'b1, 64'd0, 24'd0, 16'd0, 8'd0, 1'b0, 1'b0));
      send_item(make_request(1'b1, '1, '1, '1, '1, 1'b1, 1'b1));
      send_item(make_request(1'b0, 64'h100, 24'd1, 16'd0, 8'd1, 1'b0, 1'b0));
      send_item(make_request(1'b0, 64'h104, 24'd8193, 16'd16384, 8'd1, 1'b0, 1'b0));
      send_item(make_request(1'b0, 64'h108, 24'd1, 16'd0, 8'd1, 1'b0, 1'b0));
      send_item(make_request(1'b1, 64'd0, 24'd0, 16'd0, 8'd0, 1'b0, 1'b0));

      send_random(PHASE_ITEMS);

      send_idle_pct = 52;
      recv_idle_pct = 21;
      send_random(PHASE_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      send_random(PHASE_ITEMS);
      req_valid <= 1'b0;

      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
